>>> rtl/newton_square_root_assert.svh
// assertion macros for the newton square root block
`ifndef NEWTON_SQUARE_ROOT_ASSERT_SVH
`define NEWTON_SQUARE_ROOT_ASSERT_SVH

`ifndef SYNTHESIS
`define NSR_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("newton_square_root: check failed");
`define NSR_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("newton_square_root: check failed");
`else
`define NSR_ASSERT_IMP(name, ante, cons)
`define NSR_ASSERT_NXT(name, ante, cons)
`endif

`endif

>>> rtl/nsr_pkg.sv
// shared constants and types for the newton square root block
`default_nettype none

package nsr_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int INTEGER_BITS  = 24;

    localparam int MAG_W      = INTEGER_BITS + FRACTION_BITS;
    localparam int RADICAND_W = MAG_W + 1;
    localparam int DIV_STEPS  = MAG_W + FRACTION_BITS;
    localparam int GUESS_W    = DIV_STEPS;
    localparam int STEP_CNT_W = $clog2(DIV_STEPS);
    localparam int ROOT_W     = 29;
    localparam int ROOT_EXP   = (INTEGER_BITS + 1) / 2 + FRACTION_BITS;
    localparam int COUNT_W    = 10;

    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(64);
    localparam logic [GUESS_W-1:0] ROOT_MAX    = GUESS_W'(1) << ROOT_EXP;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_OUT
    } nsr_state_t;

endpackage

`default_nettype wire

>>> rtl/newton_square_root.sv
// Square root of a signed Q24.16 radicand by Newton iteration. Raise start while busy is low
// to issue a transaction; busy stays high until the result appears on root and
// negative_error, marked by done for exactly one cycle, which cannot be stalled. A negative
// radicand flags negative_error with root zero, and a zero radicand returns zero; both go
// from idle straight to the output state. Otherwise each of the iteration_count steps runs
// the shared bit-serial divider for 56 quotient bits, started from the check state, and
// updates the guess when the divider finishes; the reset iteration_count is 64.
// iteration_count is written through cfg_valid/cfg_data and is picked up by the next
// transaction accepted after the write; a transaction in progress keeps its own count.
`default_nettype none

module newton_square_root (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [nsr_pkg::RADICAND_W-1:0] radicand,
    output logic                                done,
    output logic [nsr_pkg::ROOT_W-1:0]          root,
    output logic                                negative_error,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [nsr_pkg::COUNT_W-1:0]    cfg_data
);
    import nsr_pkg::*;

    nsr_state_t         state_reg, state_next;
    logic [COUNT_W-1:0] count_cfg_reg, count_cfg_next;
    logic [COUNT_W-1:0] iter_reg, iter_next;
    logic [MAG_W-1:0]   x_reg, x_next;
    logic [GUESS_W-1:0] g_reg, g_next;
    logic [ROOT_W-1:0]  root_reg, root_next;
    logic               neg_reg, neg_next;

    logic               accept;
    logic               trivial;
    logic               div_start;
    logic               div_done;
    logic [GUESS_W-1:0] div_den;
    logic [GUESS_W-1:0] div_quot;
    logic [GUESS_W:0]   sum;

    assign accept  = start && !busy;
    assign trivial = radicand[MAG_W] || (radicand[MAG_W-1:0] == '0);
    // guess is never allowed below one lsb as a divisor
    assign div_den = (g_reg == '0) ? GUESS_W'(1) : g_reg;
    assign sum     = {1'b0, g_reg} + {1'b0, div_quot};

    nsr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (x_reg),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = trivial ? ST_OUT : ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = (iter_reg == '0) ? ST_OUT : ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_CHECK;
            end
            ST_OUT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        busy      = 1'b1;
        done      = 1'b0;
        div_start = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
            end
            ST_CHECK:
            begin
                div_start = (iter_reg != '0);
            end
            ST_DIV:
            begin
                busy = 1'b1;
            end
            ST_OUT:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        count_cfg_next = count_cfg_reg;
        iter_next      = iter_reg;
        x_next         = x_reg;
        g_next         = g_reg;
        root_next      = root_reg;
        neg_next       = neg_reg;
        if (cfg_valid && cfg_ready)
            count_cfg_next = cfg_data;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    x_next    = radicand[MAG_W-1:0];
                    g_next    = GUESS_W'(radicand[MAG_W-1:2]);
                    iter_next = count_cfg_reg;
                    neg_next  = radicand[MAG_W];
                    root_next = '0;
                end
            end
            ST_CHECK:
            begin
                if (iter_reg == '0)
                    root_next = (g_reg > ROOT_MAX) ? ROOT_MAX[ROOT_W-1:0] : g_reg[ROOT_W-1:0];
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    g_next    = sum[GUESS_W:1];
                    iter_next = iter_reg - COUNT_W'(1);
                end
            end
            default:
            begin
                root_next = root_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_cfg_reg <= COUNT_RESET;
            iter_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_cfg_reg <= count_cfg_next;
            iter_reg      <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        g_reg    <= g_next;
        root_reg <= root_next;
        neg_reg  <= neg_next;
    end

    assign cfg_ready      = 1'b1;
    assign root           = root_reg;
    assign negative_error = neg_reg;

`include "newton_square_root_assert.svh"

    `NSR_ASSERT_IMP(a_err_zero_root, done && negative_error, root == '0)
    `NSR_ASSERT_IMP(a_root_capped, done, root <= ROOT_MAX[ROOT_W-1:0])
    `NSR_ASSERT_NXT(a_single_strobe, done, !done && !busy)
    `NSR_ASSERT_NXT(a_busy_after_start, accept, busy)

endmodule

`default_nettype wire

>>> rtl/nsr_div.sv
// restoring fixed-point divider, one quotient bit per cycle
`default_nettype none

module nsr_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [nsr_pkg::MAG_W-1:0]   num,
    input  wire logic [nsr_pkg::GUESS_W-1:0] den,
    output logic                             done,
    output logic [nsr_pkg::GUESS_W-1:0]      quot
);
    import nsr_pkg::*;

    logic                  run_reg, run_next;
    logic                  done_reg, done_next;
    logic [STEP_CNT_W-1:0] cnt_reg, cnt_next;
    logic [GUESS_W-1:0]    rem_reg, rem_next;
    logic [DIV_STEPS-1:0]  dq_reg, dq_next;
    logic [GUESS_W-1:0]    den_reg, den_next;
    logic [GUESS_W:0]      rem_shift;
    logic [GUESS_W+1:0]    diff;

    // dividend bits leave at the top of dq while quotient bits enter at the bottom
    assign rem_shift = {rem_reg, dq_reg[DIV_STEPS-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, den_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        den_next  = den_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = STEP_CNT_W'(DIV_STEPS - 1);
            rem_next = '0;
            dq_next  = {num, FRACTION_BITS'(0)};
            den_next = den;
        end
        else if (run_reg)
        begin
            if (!diff[GUESS_W+1])
            begin
                rem_next = diff[GUESS_W-1:0];
                dq_next  = {dq_reg[DIV_STEPS-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[GUESS_W-1:0];
                dq_next  = {dq_reg[DIV_STEPS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - STEP_CNT_W'(1);
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = dq_reg;

endmodule

`default_nettype wire

>>> test/newton_square_root_tb.sv
// testbench for newton_square_root: predicted roots checked against each done pulse
`default_nettype none

module newton_square_root_tb;
    import nsr_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam logic [63:0] QUOTIENT_CAP = 64'd1 << 62;

    typedef struct {
        logic [RADICAND_W-1:0] value;
        bit                    wait_empty;
    } radicand_item_t;

    typedef struct {
        logic [ROOT_W-1:0] root;
        logic              negative_error;
    } root_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [RADICAND_W-1:0] radicand = '0;
    logic                  done;
    logic [ROOT_W-1:0]     root;
    logic                  negative_error;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [COUNT_W-1:0]    cfg_data = '0;

    radicand_item_t        pending_radicands[$];
    root_result_t          expected_roots[$];
    logic [COUNT_W-1:0]    step_count = COUNT_RESET;
    int                    roots_in_flight = 0;
    int                    idle_pct = 0;
    int                    error_count = 0;
    int                    cycle_count = 0;
    int                    idle_by_phase[4] = '{0, 82, 0, 15};
    int                    phase;
    logic                  accepted;
    radicand_item_t        next_item;
    root_result_t          got;
    root_result_t          want;

    newton_square_root dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .radicand       (radicand),
        .done           (done),
        .root           (root),
        .negative_error (negative_error),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // (num * 2^FRACTION_BITS) / den, long division with saturation
    function automatic logic [63:0] scaled_quotient(input logic [63:0] num,
                                                    input logic [63:0] den);
        logic [63:0] rem;
        logic [63:0] quo;
        logic        carry;
        logic        sat;
        logic        next_bit;
        rem = '0;
        quo = '0;
        sat = 1'b0;
        for (int i = DIV_STEPS - 1; i >= 0; i--)
        begin
            carry = rem[63];
            next_bit = 1'b0;
            if (i >= FRACTION_BITS)
                next_bit = num[i - FRACTION_BITS];
            rem = {rem[62:0], next_bit};
            quo = quo << 1;
            if (carry || rem >= den)
            begin
                rem = rem - den;
                quo[0] = 1'b1;
            end
            if (quo > QUOTIENT_CAP)
                sat = 1'b1;
            if (sat)
                quo = QUOTIENT_CAP;
        end
        return quo;
    endfunction

    function automatic root_result_t newton_root(input logic [RADICAND_W-1:0] value,
                                                 input logic [COUNT_W-1:0] steps);
        root_result_t res;
        logic [63:0]  mag;
        logic [63:0]  guess;
        res.root = '0;
        res.negative_error = 1'b0;
        if (value[MAG_W])
        begin
            res.negative_error = 1'b1;
            return res;
        end
        mag = 64'(value[MAG_W-1:0]);
        if (mag == 0)
            return res;
        guess = mag >> 2;
        for (int n = 0; n < int'(steps); n++)
        begin
            // tiny radicands truncate the guess to zero
            if (guess == 0)
                guess = 64'd1;
            guess = (guess + scaled_quotient(mag, guess)) >> 1;
        end
        if (guess > 64'(ROOT_MAX))
            guess = 64'(ROOT_MAX);
        res.root = guess[ROOT_W-1:0];
        return res;
    endfunction

    function automatic logic [RADICAND_W-1:0] random_radicand();
        logic [63:0] wide;
        int          pick;
        wide = {$urandom, $urandom};
        pick = $urandom_range(99);
        if (pick < 12)
            return {1'b1, wide[MAG_W-1:0]};
        else if (pick < 16)
            return '0;
        else if (pick < 32)
            return RADICAND_W'($urandom_range(1, 15));
        else if (pick < 50)
            return RADICAND_W'(wide[MAG_W-1:0] >> $urandom_range(8, 39));
        else
            return {1'b0, wide[MAG_W-1:0]};
    endfunction

    task automatic queue_radicand(input logic [RADICAND_W-1:0] value, input bit wait_empty);
        radicand_item_t item;
        item.value = value;
        item.wait_empty = wait_empty;
        pending_radicands.push_back(item);
    endtask

    task automatic wait_for_idle();
        do
            @(negedge clk);
        while (pending_radicands.size() != 0 || roots_in_flight != 0 || start);
    endtask

    task automatic write_iteration_count(input logic [COUNT_W-1:0] value);
        wait_for_idle();
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        step_count = value;
    endtask

    // driver: one transaction at a time, held until busy is low
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            radicand <= '0;
            roots_in_flight = 0;
        end
        else
        begin
            accepted = start && !busy;
            if (accepted)
            begin
                expected_roots.push_back(newton_root(radicand, step_count));
                roots_in_flight++;
            end
            if (done && roots_in_flight > 0)
                roots_in_flight--;
            if (!start || accepted)
            begin
                if (pending_radicands.size() != 0 && $urandom_range(99) >= idle_pct &&
                    !(pending_radicands[0].wait_empty && roots_in_flight != 0))
                begin
                    next_item = pending_radicands.pop_front();
                    start <= 1'b1;
                    radicand <= next_item.value;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            got.root = root;
            got.negative_error = negative_error;
            if (expected_roots.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual root %h error %b",
                         $time, got.root, got.negative_error);
                error_count++;
            end
            else
            begin
                want = expected_roots.pop_front();
                if (got.root !== want.root)
                begin
                    $display("%0t: root mismatch, expected %h actual %h",
                             $time, want.root, got.root);
                    error_count++;
                end
                if (got.negative_error !== want.negative_error)
                begin
                    $display("%0t: negative_error mismatch, expected %b actual %b",
                             $time, want.negative_error, got.negative_error);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset count: extremes, exact squares, tiny values
        queue_radicand('0, 0);
        queue_radicand(RADICAND_W'(1), 0);
        queue_radicand(RADICAND_W'(2), 0);
        queue_radicand(RADICAND_W'(3), 0);
        queue_radicand(RADICAND_W'(4), 0);
        queue_radicand(RADICAND_W'(32'h0000_8000), 0);
        queue_radicand(RADICAND_W'(32'h0000_FFFF), 0);
        queue_radicand(RADICAND_W'(32'h0001_0000), 1);
        queue_radicand(RADICAND_W'(32'h0002_0000), 0);
        queue_radicand(RADICAND_W'(32'h0004_0000), 0);
        queue_radicand({1'b0, {MAG_W{1'b1}}}, 0);
        queue_radicand({1'b1, {MAG_W{1'b0}}}, 0);
        queue_radicand('1, 0);

        // zero steps: root is the first guess, saturated when large
        write_iteration_count('0);
        queue_radicand({1'b0, {MAG_W{1'b1}}}, 0);
        queue_radicand(RADICAND_W'(1), 0);
        queue_radicand(RADICAND_W'(32'h0004_0000), 0);
        queue_radicand({1'b1, {MAG_W{1'b0}}}, 0);
        queue_radicand('0, 0);

        write_iteration_count(COUNT_W'(1));
        queue_radicand({1'b0, {MAG_W{1'b1}}}, 0);
        queue_radicand(RADICAND_W'(32'h0001_0000), 0);
        queue_radicand(RADICAND_W'(32'h5555_5555), 0);
        queue_radicand(RADICAND_W'(3), 0);

        write_iteration_count('1);
        queue_radicand({1'b0, {MAG_W{1'b1}}}, 0);
        queue_radicand(RADICAND_W'(32'h0001_0000), 0);

        for (phase = 0; phase < 4; phase++)
        begin
            write_iteration_count(COUNT_W'($urandom_range(1, 12)));
            idle_pct = idle_by_phase[phase];
            repeat (52) queue_radicand(random_radicand(), $urandom_range(99) < 3);
            wait_for_idle();
        end

        repeat (100) @(posedge clk);
        if (expected_roots.size() != 0)
        begin
            $display("%0t: %0d results expected but never seen", $time, expected_roots.size());
            error_count++;
        end
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
